>>> design/aco_pkg.sv
package aco_pkg;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_KEY   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  localparam logic [1:0] KEYMEM_NONE   = 2'd0;
  localparam logic [1:0] KEYMEM_RECORD = 2'd1;
  localparam logic [1:0] KEYMEM_CLEAR  = 2'd2;

  localparam logic [3:0] DIG_H    = 4'd10;
  localparam logic [3:0] DIG_F    = 4'd11;
  localparam logic [3:0] DIG_KEEP = 4'd12;

  localparam logic [1:0] CFG_TPS   = 2'd0;
  localparam logic [1:0] CFG_SPLIT = 2'd1;
  localparam logic [1:0] CFG_MAXH  = 2'd2;

  localparam logic [7:0] TPS_RESET   = 8'd99;
  localparam logic [7:0] SPLIT_RESET = 8'd64;
  localparam logic [3:0] MAXH_LIMIT  = 4'd9;

  localparam logic [5:0] SEC_TOP    = 6'd59;
  localparam logic [5:0] MIN_TOP    = 6'd59;
  localparam logic [5:0] MIN_HALF   = 6'd30;
  localparam logic [5:0] MIN_HALF_1 = 6'd29;

  typedef struct packed {
    logic [1:0] func;
    logic       powered_on;
    logic       error_active;
    logic       last_key_was_timer;
  } aco_in_t;

  typedef struct packed {
    logic       running;
    logic [3:0] hours_left;
    logic [5:0] minutes_left;
    logic [5:0] seconds_left;
    logic       set_view;
    logic [3:0] digit_left;
    logic [3:0] digit_mid;
    logic [3:0] digit_right;
    logic       colon_on;
    logic       power_on_request;
    logic       standby_request;
    logic [1:0] key_memory;
  } aco_out_t;

  typedef struct packed {
    logic       run;
    logic [7:0] tick;
    logic [5:0] sec;
    logic [5:0] min;
    logic [3:0] hr;
    logic       pview;
    logic       flash;
  } aco_state_t;

  typedef struct packed {
    logic [7:0] tps;
    logic [7:0] split;
    logic [3:0] maxh;
  } aco_cfg_t;

  typedef struct packed {
    logic       power_req;
    logic       standby_req;
    logic [1:0] keymem;
  } aco_flags_t;

  typedef struct packed {
    logic [3:0] dl;
    logic [3:0] dm;
    logic [3:0] dr;
    logic       colon;
  } aco_disp_t;

  function automatic logic [2:0] tens_of(input logic [5:0] m);
    logic [2:0] q;
    if (m >= 6'd60) q = 3'd6;
    else if (m >= 6'd50) q = 3'd5;
    else if (m >= 6'd40) q = 3'd4;
    else if (m >= 6'd30) q = 3'd3;
    else if (m >= 6'd20) q = 3'd2;
    else if (m >= 6'd10) q = 3'd1;
    else q = 3'd0;
    return q;
  endfunction

endpackage

>>> design/aco_core.sv
module aco_core (
  input  aco_pkg::aco_state_t st_i,
  input  aco_pkg::aco_cfg_t   cfg_i,
  input  aco_pkg::aco_in_t    item_i,
  output aco_pkg::aco_state_t st_o,
  output aco_pkg::aco_flags_t flags_o
);
  import aco_pkg::*;

  logic [7:0] tick_inc;
  logic       expired;
  logic       timer_key;
  logic       zero_time;

  assign tick_inc  = st_i.tick + 8'd1;
  assign zero_time = (st_i.min == 6'd0) && (st_i.hr == 4'd0);

  always_comb begin
    st_o      = st_i;
    flags_o   = '0;
    expired   = 1'b0;
    timer_key = item_i.last_key_was_timer;
    case (item_i.func)
      FUNC_TICK: begin
        if (st_i.run) begin
          st_o.tick = tick_inc;
          if (tick_inc > cfg_i.tps) begin
            st_o.tick = 8'd0;
            if (st_i.sec == 6'd0 || st_i.sec > SEC_TOP) begin
              st_o.sec = SEC_TOP;
              if (st_i.min == 6'd0 || st_i.min > MIN_TOP) begin
                st_o.min = MIN_TOP;
                if (st_i.hr == 4'd0) begin
                  expired = 1'b1;
                end else begin
                  st_o.hr = st_i.hr - 4'd1;
                end
              end else begin
                st_o.min = st_i.min - 6'd1;
              end
            end else begin
              st_o.sec = st_i.sec - 6'd1;
            end
            if (expired || (st_o.min == 6'd0 && st_o.hr == 4'd0)) begin
              st_o.run            = 1'b0;
              st_o.sec            = 6'd0;
              st_o.min            = 6'd0;
              st_o.hr             = 4'd0;
              flags_o.standby_req = 1'b1;
              flags_o.keymem      = KEYMEM_CLEAR;
            end
          end
          st_o.flash = (st_o.tick < cfg_i.split) ? 1'b0 : 1'b1;
        end
      end
      FUNC_KEY: begin
        if (!item_i.powered_on) begin
          flags_o.power_req = 1'b1;
          timer_key         = 1'b0;
        end
        if (item_i.powered_on || !item_i.error_active) begin
          flags_o.keymem = KEYMEM_RECORD;
          if (timer_key || zero_time) begin
            st_o.pview = 1'b1;
            st_o.sec   = SEC_TOP;
            st_o.tick  = 8'd0;
            st_o.run   = 1'b1;
            if (st_i.hr == 4'd0) begin
              if (st_i.min <= MIN_HALF_1) begin
                st_o.min = MIN_HALF;
              end else if (st_i.min <= MIN_TOP) begin
                st_o.min = 6'd0;
                st_o.hr  = 4'd1;
              end
            end else if ({1'b0, st_i.hr} + 5'd1 > {1'b0, cfg_i.maxh}) begin
              st_o.run  = 1'b0;
              st_o.sec  = 6'd0;
              st_o.min  = 6'd0;
              st_o.hr   = 4'd0;
              st_o.tick = st_i.tick;
            end else begin
              st_o.hr  = st_i.hr + 4'd1;
              st_o.min = 6'd0;
            end
          end else begin
            st_o.pview = 1'b0;
          end
        end
      end
      FUNC_CLEAR: begin
        st_o.run  = 1'b0;
        st_o.sec  = 6'd0;
        st_o.min  = 6'd0;
        st_o.hr   = 4'd0;
        st_o.tick = 8'd0;
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

endmodule

>>> design/aco_display.sv
module aco_display (
  input  aco_pkg::aco_state_t st_i,
  output aco_pkg::aco_disp_t  disp_o
);
  import aco_pkg::*;

  logic [2:0] tens;
  logic [5:0] ones;

  assign tens = tens_of(st_i.min);
  assign ones = st_i.min - 6'({3'd0, tens} * 6'd10);

  always_comb begin
    disp_o = '0;
    if (st_i.sec != 6'd0 || st_i.min != 6'd0 || st_i.hr != 4'd0) begin
      if (st_i.pview && st_i.hr != 4'd0) begin
        disp_o.dl = DIG_KEEP;
        disp_o.dm = st_i.hr;
        disp_o.dr = DIG_H;
      end else begin
        disp_o.dl    = st_i.pview ? DIG_KEEP : st_i.hr;
        disp_o.dm    = {1'b0, tens};
        disp_o.dr    = ones[3:0];
        disp_o.colon = !st_i.pview && !st_i.flash;
      end
    end else begin
      disp_o.dl = 4'd0;
      disp_o.dm = DIG_F;
      disp_o.dr = DIG_F;
    end
  end

endmodule

>>> design/appliance_countdown_off_timer_unit.sv
// Pipeline: a word is held in the input register and its result is captured in the result
// register as it advances, which it does only while the result register is empty or unstalled.
// Throughput: one word per cycle while the output is not stalled; the timer state updates as
// each word leaves the input register, so the next word sees the updated state.
// Reset (rst_ni low, asynchronous): timer stopped, time, tick count, view and flash
// cleared, registers back to 99 / 64 / 9, both pipeline stages empty.
module appliance_countdown_off_timer_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  aco_pkg::aco_in_t in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output aco_pkg::aco_out_t out_word_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i
);
  import aco_pkg::*;

  aco_cfg_t   cfg_q;
  aco_state_t st_q, st_d;
  aco_flags_t flags;
  aco_disp_t  disp;
  aco_in_t    item_q;
  logic       item_vld_q;
  aco_out_t   res_q;
  logic       res_vld_q;
  logic       advance;

  assign advance     = item_vld_q && (!res_vld_q || !out_stall_i);
  assign in_stall_o  = item_vld_q && !advance;
  assign out_valid_o = res_vld_q;
  assign out_word_o  = res_q;
  assign cfg_ready_o = 1'b1;

  aco_core u_core (
    .st_i    (st_q),
    .cfg_i   (cfg_q),
    .item_i  (item_q),
    .st_o    (st_d),
    .flags_o (flags)
  );

  aco_display u_display (
    .st_i   (st_d),
    .disp_o (disp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tps   <= TPS_RESET;
      cfg_q.split <= SPLIT_RESET;
      cfg_q.maxh  <= MAXH_LIMIT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TPS:   cfg_q.tps   <= cfg_data_i;
        CFG_SPLIT: cfg_q.split <= cfg_data_i;
        CFG_MAXH: begin
          cfg_q.maxh <= (cfg_data_i[3:0] > MAXH_LIMIT) ? MAXH_LIMIT : cfg_data_i[3:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (!item_vld_q || advance) begin
        item_vld_q <= in_valid_i;
      end
      if (advance) begin
        st_q      <= st_d;
        res_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!item_vld_q || advance) && in_valid_i) begin
      item_q <= in_word_i;
    end
    if (advance) begin
      res_q.running          <= st_d.run;
      res_q.hours_left       <= st_d.hr;
      res_q.minutes_left     <= st_d.min;
      res_q.seconds_left     <= st_d.sec;
      res_q.set_view         <= st_d.pview;
      res_q.digit_left       <= disp.dl;
      res_q.digit_mid        <= disp.dm;
      res_q.digit_right      <= disp.dr;
      res_q.colon_on         <= disp.colon;
      res_q.power_on_request <= flags.power_req;
      res_q.standby_request  <= flags.standby_req;
      res_q.key_memory       <= flags.keymem;
    end
  end

endmodule
